/* design/tdfm_pkg.sv */
package tdfm_pkg;

    // Frame bytes
    localparam logic [7:0] HDR0  = 8'h55;
    localparam logic [7:0] HDR1  = 8'h0A;
    localparam logic [7:0] MARK0 = 8'h05;
    localparam logic [7:0] MARK1 = 8'h02;

    // Reset value of the close threshold
    localparam logic [15:0] THRESH_RESET = 16'd70;

    // Configuration register indexes
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_THRESH = 1'b1;

    // Offset of the next expected frame byte
    typedef enum logic [3:0] {
        POS_IDLE  = 4'd0,
        POS_HDR1  = 4'd1,
        POS_SKIP0 = 4'd2,
        POS_SKIP1 = 4'd3,
        POS_SKIP2 = 4'd4,
        POS_SKIP3 = 4'd5,
        POS_MARK0 = 4'd6,
        POS_MARK1 = 4'd7,
        POS_DHI   = 4'd8,
        POS_DLO   = 4'd9
    } t_pos;

    // Framer to filter: one decoded distance
    typedef struct packed {
        logic        done;
        logic [15:0] dval;
    } t_frame_evt;

    // Filter result for one frame
    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] filtered;
        logic        updated;
        logic        close;
    } t_result;

endpackage

/* design/tdfm_framer.sv */
module tdfm_framer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output logic                  o_at_last,
    output tdfm_pkg::t_frame_evt  o_evt
);
    import tdfm_pkg::*;

    t_pos       r_pos, n_pos;
    logic [7:0] r_dhi, n_dhi;
    logic [3:0] w_resync;

    // A 0x55 on a mismatch starts a new header
    assign w_resync = (i_byte == HDR0) ? POS_HDR1 : POS_IDLE;

    // Next frame position
    always_comb begin
        n_pos = r_pos;
        n_dhi = r_dhi;
        case (r_pos)
            POS_HDR1: begin
                n_pos = (i_byte == HDR1) ? POS_SKIP0 : t_pos'(w_resync);
            end
            POS_SKIP0, POS_SKIP1, POS_SKIP2, POS_SKIP3: begin
                n_pos = t_pos'(r_pos + 4'd1);
            end
            POS_MARK0: begin
                n_pos = (i_byte == MARK0) ? POS_MARK1 : t_pos'(w_resync);
            end
            POS_MARK1: begin
                n_pos = (i_byte == MARK1) ? POS_DHI : t_pos'(w_resync);
            end
            POS_DHI: begin
                n_dhi = i_byte;
                n_pos = POS_DLO;
            end
            POS_DLO: begin
                n_pos = POS_IDLE;
            end
            default: begin
                n_pos = t_pos'(w_resync);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_IDLE;
            r_dhi <= 8'd0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_dhi <= n_dhi;
        end
    end

    assign o_at_last  = (r_pos == POS_DLO);
    assign o_evt.done = i_step && (r_pos == POS_DLO);
    assign o_evt.dval = {r_dhi, i_byte};

`ifndef SYNTH
    // Completed frame always returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt.done |=> (r_pos == POS_IDLE))
        else $error("framer did not return to idle after a frame");
    // Position never leaves the frame range
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_DLO)
        else $error("frame position out of range");
    // Skipped bytes advance by one whatever their value
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_pos == POS_SKIP0) |=> (r_pos == POS_SKIP1))
        else $error("skip offset did not advance");
`endif

endmodule

/* design/tdfm_median.sv */
module tdfm_median (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tdfm_pkg::t_frame_evt  i_evt,
    input  logic [15:0]           i_thresh,
    output tdfm_pkg::t_result     o_res
);
    import tdfm_pkg::*;

    logic [15:0] r_s0, r_s1;
    logic [1:0]  r_count;
    logic [15:0] r_held;
    logic [15:0] w_lo, w_hi, w_med, w_held;
    logic        w_full;

    // Third sample completes the block
    assign w_full = i_evt.done && (r_count == 2'd2);

    // Median of the two stored samples and the new one
    always_comb begin
        w_lo = (r_s0 < r_s1) ? r_s0 : r_s1;
        w_hi = (r_s0 < r_s1) ? r_s1 : r_s0;
        if (i_evt.dval <= w_lo) begin
            w_med = w_lo;
        end else if (i_evt.dval >= w_hi) begin
            w_med = w_hi;
        end else begin
            w_med = i_evt.dval;
        end
    end

    assign w_held = w_full ? w_med : r_held;

    // Sample store, no reset: each entry is written before the median reads it
    always_ff @(posedge i_clk) begin
        if (i_evt.done && r_count == 2'd0) begin
            r_s0 <= i_evt.dval;
        end
        if (i_evt.done && r_count == 2'd1) begin
            r_s1 <= i_evt.dval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_held  <= 16'd0;
        end else if (i_evt.done) begin
            r_count <= w_full ? 2'd0 : r_count + 2'd1;
            r_held  <= w_held;
        end
    end

    assign o_res.distance = i_evt.dval;
    assign o_res.filtered = w_held;
    assign o_res.updated  = w_full;
    assign o_res.close    = (w_held != 16'd0) && (w_held <= i_thresh);

`ifndef SYNTH
    // Block count wraps after three samples
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("block count reached three");
    // A full block restarts the count
    a_full_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |=> (r_count == 2'd0))
        else $error("block count did not wrap");
    // Held median changes only when a block completes
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |=> $stable(r_held))
        else $error("held median changed without a full block");
`endif

endmodule

/* design/tof_distance_frame_median.sv */
// Channel  Direction  Handshake                Payload
// rx       in         i_rx_valid / o_rx_ready  i_rx_byte[7:0]
// res      out        o_res_valid / i_res_ready o_distance, o_filtered_distance,
//                                              o_filtered_updated, o_grip_close
// cfg      in         i_cfg_we                 i_cfg_index, i_cfg_data[15:0]
//
// One byte per cycle; a completed frame shows its result on the cycle after
// the last distance byte is taken, from the output register.
// Synchronous active-low reset clears framing, block count, held median and
// configuration (threshold to 70, disabled). Bytes that complete no frame are
// taken even while a result waits; only the last frame byte stalls, while the
// output register still holds an untaken result.
module tof_distance_frame_median (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [15:0] o_distance,
    output logic [15:0] o_filtered_distance,
    output logic        o_filtered_updated,
    output logic        o_grip_close,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import tdfm_pkg::*;

    logic       r_enable;
    logic [15:0] r_thresh;
    logic       r_valid;
    t_result    r_res;
    logic       w_accept, w_step, w_at_last, w_stall;
    t_frame_evt w_evt;
    t_result    w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_THRESH: r_thresh <= i_cfg_data;
                default:    r_enable <= r_enable;
            endcase
        end
    end

    // Hold off only the byte that would need the busy output register
    assign w_stall    = r_valid && !i_res_ready && r_enable && w_at_last;
    assign o_rx_ready = !w_stall;
    assign w_accept   = i_rx_valid && o_rx_ready;
    assign w_step     = w_accept && r_enable;

    tdfm_framer u_framer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_byte    (i_rx_byte),
        .o_at_last (w_at_last),
        .o_evt     (w_evt)
    );

    tdfm_median u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (w_evt),
        .i_thresh (r_thresh),
        .o_res    (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_evt.done) begin
            r_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt.done) begin
            r_res <= w_res;
        end
    end

    assign o_res_valid         = r_valid;
    assign o_distance          = r_res.distance;
    assign o_filtered_distance = r_res.filtered;
    assign o_filtered_updated  = r_res.updated;
    assign o_grip_close        = r_res.close;

`ifndef SYNTH
    // A new result never overwrites one that is still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_evt.done |-> (!r_valid || i_res_ready))
        else $error("result overwritten before transaction");
    // A waiting result survives a stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_res_ready) |=> r_valid)
        else $error("result dropped while stalled");
    // Disabled: no frame completes
    a_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enable |-> !w_evt.done)
        else $error("frame completed while disabled");
`endif

endmodule
